FILE: src/windowed_near_duplicate_detector_core_macros.svh
// Assertion macros shared by the near-duplicate detector modules.
`ifndef WINDOWED_NEAR_DUPLICATE_DETECTOR_CORE_MACROS_SVH
`define WINDOWED_NEAR_DUPLICATE_DETECTOR_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define WNDD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define WNDD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/wndd_pkg.sv
// Shared constants and types of the windowed near-duplicate detector.
package wndd_pkg;

  // Deepest window the cell row holds (1 to 127, bounded by the WLEN_W-bit window_len).
  localparam int WINDOW_MAX = 64;

  // Field and register widths.
  localparam int SAMPLE_W  = 32;
  localparam int TOL_W     = 31;
  localparam int WLEN_W    = 7;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;

  // Hit bits are folded in groups of this size, one register level per fold.
  localparam int GROUP      = 8;
  localparam int NUM_GROUPS = (WINDOW_MAX + GROUP - 1) / GROUP;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 1'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [TOL_W-1:0]           tol_t;

  // Control that travels alongside an item through the pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

FILE: src/windowed_near_duplicate_detector_core.sv
// Top level of the windowed near-duplicate detector.
// Takes one item per clock while in_stall is low. Each sample is compared in
// parallel against a row of WINDOW_MAX cells holding the most recent samples of
// the sequence; a cell counts when it is occupied and lies within window_len of
// the newest. Hit bits are folded in two registered levels, and the row, the
// folds and the output register each hold one item at a time. The compare row sets
// the one-cycle item rate. found_so_far is the sticky match flag of the sequence;
// after an item with last set, the window and the flag start empty. Configuration
// must be written only while no item is in flight; the block does not enforce it.
`include "windowed_near_duplicate_detector_core_macros.svh"

module windowed_near_duplicate_detector_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [wndd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wndd_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [31:0]             sample,
  input  logic                           last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           match_here,
  output logic                           found_so_far,
  output logic                           end_of_sequence
);

  logic [wndd_pkg::WLEN_W-1:0]     window_len;
  wndd_pkg::tol_t                  tolerance;
  wndd_pkg::stage_ctrl_t           s1;
  logic                            s1_ready;
  logic                            s2_ready;
  logic                            accept;
  logic [wndd_pkg::WINDOW_MAX-1:0] span_ok;
  logic [wndd_pkg::WINDOW_MAX-1:0] occ_vec;
  logic [wndd_pkg::WINDOW_MAX-1:0] hits;
  wndd_pkg::sample_t               vals [wndd_pkg::WINDOW_MAX];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= wndd_pkg::WLEN_W'(1);
      tolerance  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        wndd_pkg::REG_WINDOW_LEN: window_len <= cfg_data[wndd_pkg::WLEN_W-1:0];
        wndd_pkg::REG_TOLERANCE:  tolerance  <= cfg_data[wndd_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Input handshake: the compare stage moves when it is empty or drains.
  assign s1_ready = !s1.valid || s2_ready;
  assign in_stall = !s1_ready;
  assign accept   = in_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else if (s1_ready) begin
      s1.valid <= in_valid;
    end
    if (s1_ready) begin
      s1.last <= last;
    end
  end

  // Row of cells; cell 0 takes the new sample, each later cell its neighbor's.
  for (genvar i = 0; i < wndd_pkg::WINDOW_MAX; i++) begin : g_cell
    wndd_pkg::sample_t prev_value;
    logic              prev_occ;

    assign span_ok[i] = (32'(window_len) > 32'(i));

    if (i == 0) begin : g_head
      assign prev_value = sample;
      assign prev_occ   = 1'b1;
    end else begin : g_body
      assign prev_value = vals[i-1];
      assign prev_occ   = occ_vec[i-1];
    end

    wndd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift      (accept),
      .clear      (last),
      .load       (s1_ready),
      .span_ok    (span_ok[i]),
      .sample_in  (sample),
      .tol        (tolerance),
      .prev_value (prev_value),
      .prev_occ   (prev_occ),
      .value      (vals[i]),
      .occ        (occ_vec[i]),
      .hit        (hits[i])
    );
  end

  // Fold hits, track the sequence flag, drive the result.
  wndd_reduce u_reduce (
    .clk             (clk),
    .rst             (rst),
    .s1              (s1),
    .hits            (hits),
    .s2_ready        (s2_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .match_here      (match_here),
    .found_so_far    (found_so_far),
    .end_of_sequence (end_of_sequence)
  );

  `WNDD_ASSERT(a_free_when_empty, !out_valid |-> !in_stall, "input stalled with empty output")
  `WNDD_ASSERT(a_last_empties, (in_valid && !in_stall && last) |=> !occ_vec[0], "window not emptied after last item")
  `WNDD_ASSERT(a_occ_thermo, ((occ_vec & (occ_vec + 1'b1)) == '0), "cell occupancy not contiguous")

endmodule

FILE: src/wndd_cell.sv
// One window cell: holds a sample, shifts it on, and compares it to a new item.
module wndd_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic              clear,
  input  logic              load,
  input  logic              span_ok,
  input  wndd_pkg::sample_t sample_in,
  input  wndd_pkg::tol_t    tol,
  input  wndd_pkg::sample_t prev_value,
  input  logic              prev_occ,
  output wndd_pkg::sample_t value,
  output logic              occ,
  output logic              hit
);

  logic signed [wndd_pkg::SAMPLE_W:0] diff;
  logic signed [wndd_pkg::SAMPLE_W:0] tol_pos;
  logic signed [wndd_pkg::SAMPLE_W:0] tol_neg;
  logic                               in_tol;

  // Difference at 33 bits never overflows; in tolerance when -tol <= d <= tol.
  assign diff    = {sample_in[wndd_pkg::SAMPLE_W-1], sample_in}
                 - {value[wndd_pkg::SAMPLE_W-1], value};
  assign tol_pos = {2'b00, tol};
  assign tol_neg = '0 - tol_pos;
  assign in_tol  = (diff <= tol_pos) && (diff >= tol_neg);

  // Occupancy: shifts along with the sample, cleared after the last item.
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (shift) begin
      occ <= clear ? 1'b0 : prev_occ;
    end
  end

  // Stored sample; contents do not matter while unoccupied.
  always_ff @(posedge clk) begin
    if (shift && !clear) begin
      value <= prev_value;
    end
  end

  // Compare result against the window as it stood before the shift.
  always_ff @(posedge clk) begin
    if (load) begin
      hit <= occ && span_ok && in_tol;
    end
  end

endmodule

FILE: src/wndd_reduce.sv
// Folds the cell hit bits over two register levels and keeps the sticky flag.
`include "windowed_near_duplicate_detector_core_macros.svh"

module wndd_reduce (
  input  logic                            clk,
  input  logic                            rst,
  input  wndd_pkg::stage_ctrl_t           s1,
  input  logic [wndd_pkg::WINDOW_MAX-1:0] hits,
  output logic                            s2_ready,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            match_here,
  output logic                            found_so_far,
  output logic                            end_of_sequence
);

  logic [wndd_pkg::GROUP-1:0]      grp_bits [wndd_pkg::NUM_GROUPS];
  logic [wndd_pkg::NUM_GROUPS-1:0] grp_next;
  logic [wndd_pkg::NUM_GROUPS-1:0] grp;
  wndd_pkg::stage_ctrl_t           s2;
  logic                            out_ready;
  logic                            any_hit;
  logic                            sticky;

  // Group the hit bits; slots past the last cell read as zero.
  for (genvar g = 0; g < wndd_pkg::NUM_GROUPS; g++) begin : g_grp
    for (genvar j = 0; j < wndd_pkg::GROUP; j++) begin : g_bit
      if (g * wndd_pkg::GROUP + j < wndd_pkg::WINDOW_MAX) begin : g_live
        assign grp_bits[g][j] = hits[g * wndd_pkg::GROUP + j];
      end else begin : g_pad
        assign grp_bits[g][j] = 1'b0;
      end
    end
    assign grp_next[g] = |grp_bits[g];
  end

  assign any_hit   = |grp;
  assign out_ready = !out_valid || !out_stall;
  assign s2_ready  = !s2.valid || out_ready;

  // Second level: group results.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else if (s2_ready) begin
      s2.valid <= s1.valid;
    end
    if (s2_ready) begin
      s2.last <= s1.last;
      grp     <= grp_next;
    end
  end

  // Output register and sticky flag; items arrive here in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sticky    <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s2.valid;
      if (s2.valid) begin
        sticky <= s2.last ? 1'b0 : (sticky || any_hit);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      match_here      <= any_hit;
      found_so_far    <= sticky || any_hit;
      end_of_sequence <= s2.last;
    end
  end

  `WNDD_ASSERT(a_sticky_clears, (out_valid && !out_stall && end_of_sequence) |=> !sticky, "sticky flag survived end of sequence")
  `WNDD_ASSERT(a_match_sets_found, (out_valid && match_here) |-> found_so_far, "match without found flag")

endmodule
